FILE: rtl/polar_rectangular_converter_assert.svh
// Assertion macros shared by the converter's checker.
`ifndef POLAR_RECTANGULAR_CONVERTER_ASSERT_SVH
`define POLAR_RECTANGULAR_CONVERTER_ASSERT_SVH

// Same-cycle implication, quiet while reset is high.
`define PRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication that also holds across reset.
`define PRC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/prc_pkg.sv
// Types, constants and the arctangent table of the polar/rectangular converter.
package prc_pkg;

  localparam int IN_A_W     = 16;
  localparam int IN_B_W     = 17;
  localparam int OUT_W      = 17;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 40;
  localparam int VW         = 32;
  localparam int ZW         = 32;
  localparam int FRAC       = 12;
  localparam int MAG_MAX    = 46341;
  localparam logic [63:0] K_Q32 = 64'd2608131496;

  localparam logic REQ_P2C = 1'b0;
  localparam logic REQ_C2P = 1'b1;

  typedef struct packed {
    logic                 op;
    logic                 zero;
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [ZW-1:0]        z;
  } prc_vec_t;

  function automatic logic [31:0] gain_q32(input int iterations);
    logic [63:0] corr;
    int          s;
    begin
      s = 2 * iterations - 1;
      corr = (s < 64) ? ((K_Q32 / 64'd3) >> s) : 64'd0;
      return 32'(K_Q32 + corr);
    end
  endfunction

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    begin
      case (idx)
        5'd0:    return 32'd536870912;
        5'd1:    return 32'd316933406;
        5'd2:    return 32'd167458907;
        5'd3:    return 32'd85004756;
        5'd4:    return 32'd42667331;
        5'd5:    return 32'd21354465;
        5'd6:    return 32'd10680862;
        5'd7:    return 32'd5340245;
        5'd8:    return 32'd2670163;
        5'd9:    return 32'd1335087;
        5'd10:   return 32'd667544;
        5'd11:   return 32'd333772;
        5'd12:   return 32'd166886;
        5'd13:   return 32'd83443;
        5'd14:   return 32'd41722;
        5'd15:   return 32'd20861;
        5'd16:   return 32'd10430;
        5'd17:   return 32'd5215;
        5'd18:   return 32'd2608;
        5'd19:   return 32'd1304;
        5'd20:   return 32'd652;
        5'd21:   return 32'd326;
        5'd22:   return 32'd163;
        5'd23:   return 32'd81;
        5'd24:   return 32'd41;
        5'd25:   return 32'd20;
        5'd26:   return 32'd10;
        5'd27:   return 32'd5;
        5'd28:   return 32'd3;
        5'd29:   return 32'd1;
        5'd30:   return 32'd1;
        default: return 32'd0;
      endcase
    end
  endfunction

endpackage

FILE: rtl/polar_rectangular_converter.sv
// Top level of the CORDIC polar/rectangular converter.
// One word is taken per clock cycle while the output is not stalled, and every word gives
// one result word after passing one input stage, a row of ITERATIONS rotation cells,
// a gain-multiply stage and the output register. Each stage holds its own word, so a
// stall on the output only stops the stages behind it that are full, and bubbles close up.
module polar_rectangular_converter #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: in_a[15:0], in_b[32:16], zero fill [39:33].
  input  logic [prc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Fields from bit 0: req_type.
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: out_a[16:0], out_b[33:17], zero fill [39:34].
  output logic [prc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: out_type.
  output logic                          m_axis_tuser
);
  import prc_pkg::*;

  logic             valid [ITERATIONS+1];
  logic             ready [ITERATIONS+1];
  prc_vec_t         vec   [ITERATIONS+1];
  logic [OUT_W-1:0] res_a;
  logic [OUT_W-1:0] res_b;

  prc_prep #(
    .DATA_WIDTH (DATA_WIDTH),
    .ITERATIONS (ITERATIONS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_a      (s_axis_tdata[IN_A_W-1:0]),
    .in_b      (s_axis_tdata[IN_A_W+IN_B_W-1:IN_A_W]),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_vec   (vec[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    prc_cell #(
      .STAGE (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_vec    (vec[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .out_vec   (vec[i+1])
    );
  end

  prc_post #(
    .DATA_WIDTH (DATA_WIDTH),
    .ITERATIONS (ITERATIONS)
  ) u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[ITERATIONS]),
    .in_ready  (ready[ITERATIONS]),
    .in_vec    (vec[ITERATIONS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_a     (res_a),
    .out_b     (res_b),
    .out_type  (m_axis_tuser)
  );

  assign m_axis_tdata = {{(M_TDATA_W - 2 * OUT_W){1'b0}}, res_b, res_a};

endmodule

FILE: rtl/prc_prep.sv
// Input stage: gain-scaled start vector for polar requests and a quadrant fold for both operations.
module prc_prep #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [prc_pkg::IN_A_W-1:0]    in_a,
  input  logic [prc_pkg::IN_B_W-1:0]    in_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output prc_pkg::prc_vec_t             out_vec
);
  import prc_pkg::*;

  localparam logic [31:0]        GAIN = gain_q32(ITERATIONS);
  localparam logic signed [32:0] CMAX = (33'sd1 <<< (DATA_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] CMIN = -CMAX - 33'sd1;
  localparam int                 PW   = IN_A_W - 1 + 32;

  logic [IN_A_W-2:0]    mag_in;
  logic [PW-1:0]        prod;
  logic [PW-1:0]        prod_rnd;
  logic signed [VW-1:0] xr;
  logic [ZW-1:0]        z_p2c;
  logic                 flip;
  logic signed [32:0]   yw;
  logic signed [32:0]   yc;
  logic signed [VW-1:0] xa;
  logic signed [VW-1:0] ya;
  prc_vec_t             vec_next;
  prc_vec_t             vec;
  logic                 valid;

  always_comb begin
    mag_in   = in_a[IN_A_W-1] ? '0 : in_a[IN_A_W-2:0];
    prod     = PW'(mag_in) * PW'(GAIN);
    prod_rnd = prod + (PW'(1) << (31 - FRAC));
    xr       = VW'(prod_rnd >> (32 - FRAC));
    z_p2c    = {in_b[15:0], 16'h0000};
    flip     = z_p2c[ZW-1] ^ z_p2c[ZW-2];
    yw       = {{(33 - IN_B_W){in_b[IN_B_W-1]}}, in_b};
    yc       = (yw < CMIN) ? CMIN : ((yw > CMAX) ? CMAX : yw);
    xa       = {{(VW - IN_A_W){in_a[IN_A_W-1]}}, in_a};
    ya       = yc[VW-1:0];
    vec_next.op   = in_op;
    vec_next.zero = 1'b0;
    if (in_op == REQ_P2C) begin
      vec_next.x = flip ? -xr : xr;
      vec_next.y = '0;
      vec_next.z = {z_p2c[ZW-1] ^ flip, z_p2c[ZW-2:0]};
    end else begin
      vec_next.zero = (xa == '0) && (ya == '0);
      if (xa[VW-1]) begin
        vec_next.x = (-xa) <<< FRAC;
        vec_next.y = (-ya) <<< FRAC;
        vec_next.z = {1'b1, {(ZW - 1){1'b0}}};
      end else begin
        vec_next.x = xa <<< FRAC;
        vec_next.y = ya <<< FRAC;
        vec_next.z = '0;
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_vec   = vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vec <= vec_next;
    end
  end

endmodule

FILE: rtl/prc_cell.sv
// One CORDIC micro-rotation cell with its own handshake register.
module prc_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  prc_pkg::prc_vec_t in_vec,
  output logic              out_valid,
  input  logic              out_ready,
  output prc_pkg::prc_vec_t out_vec
);
  import prc_pkg::*;

  localparam logic [31:0] ATAN = atan_turn(5'(STAGE));

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  logic                 sub;
  prc_vec_t             vec_next;
  prc_vec_t             vec;
  logic                 valid;

  always_comb begin
    xs  = in_vec.x >>> STAGE;
    ys  = in_vec.y >>> STAGE;
    sub = (in_vec.op == REQ_C2P) ? in_vec.y[VW-1] : !in_vec.z[ZW-1];
    vec_next = in_vec;
    if (sub) begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - ATAN;
    end else begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + ATAN;
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_vec   = vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      vec <= vec_next;
    end
  end

endmodule

FILE: rtl/prc_post.sv
// Output stages: magnitude gain product, then rounding, saturation and the result word.
module prc_post #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  prc_pkg::prc_vec_t        in_vec,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [prc_pkg::OUT_W-1:0] out_a,
  output logic [prc_pkg::OUT_W-1:0] out_b,
  output logic                     out_type
);
  import prc_pkg::*;

  localparam logic [31:0]        GAIN = gain_q32(ITERATIONS);
  localparam logic signed [32:0] CMAX = (33'sd1 <<< (DATA_WIDTH - 1)) - 33'sd1;
  localparam logic signed [32:0] CMIN = -CMAX - 33'sd1;

  logic                 v1;
  logic                 v2;
  logic                 r1;
  logic                 r2;
  prc_vec_t             vec1;
  logic [62:0]          prod;
  logic [62:0]          prod_next;
  logic [VW-2:0]        xnn;
  logic [63:0]          mag_sum;
  logic [19:0]          mag;
  logic signed [VW-1:0] rx;
  logic signed [VW-1:0] ry;
  logic signed [32:0]   cx;
  logic signed [32:0]   cy;
  logic [ZW-1:0]        zr;
  logic [OUT_W-1:0]     a_next;
  logic [OUT_W-1:0]     b_next;

  always_comb begin
    xnn       = in_vec.x[VW-1] ? '0 : in_vec.x[VW-2:0];
    prod_next = 63'(xnn) * 63'(GAIN);
  end

  always_comb begin
    mag_sum = 64'(prod) + (64'd1 << (FRAC + 31));
    mag     = 20'(mag_sum >> (FRAC + 32));
    rx      = (vec1.x + (VW'(1) <<< (FRAC - 1))) >>> FRAC;
    ry      = (vec1.y + (VW'(1) <<< (FRAC - 1))) >>> FRAC;
    cx      = 33'(rx);
    cy      = 33'(ry);
    cx      = (cx < CMIN) ? CMIN : ((cx > CMAX) ? CMAX : cx);
    cy      = (cy < CMIN) ? CMIN : ((cy > CMAX) ? CMAX : cy);
    zr      = vec1.z + 32'h0000_8000;
    if (vec1.op == REQ_P2C) begin
      a_next = cx[OUT_W-1:0];
      b_next = cy[OUT_W-1:0];
    end else if (vec1.zero) begin
      a_next = '0;
      b_next = '0;
    end else begin
      a_next = (mag > 20'(MAG_MAX)) ? OUT_W'(MAG_MAX) : mag[OUT_W-1:0];
      b_next = {1'b0, zr[ZW-1:16]};
    end
  end

  assign r2        = !v2 || out_ready;
  assign r1        = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid;
      end
      if (r2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      vec1 <= in_vec;
      prod <= prod_next;
    end
    if (r2 && v1) begin
      out_a    <= a_next;
      out_b    <= b_next;
      out_type <= vec1.op;
    end
  end

endmodule

FILE: rtl/prc_checker.sv
// Port-level checker for the converter and its bind to the top level.
`include "polar_rectangular_converter_assert.svh"

module prc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [prc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [prc_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser
);
  import prc_pkg::*;

  logic polar_word;

  assign polar_word = m_axis_tvalid && (m_axis_tuser == REQ_C2P);

  `PRC_ASSERT_ALWAYS(a_reset_clears, $past(rst), !m_axis_tvalid, "output valid after reset")
  `PRC_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled word changed")
  `PRC_ASSERT_NOW(a_mag_range, polar_word, m_axis_tdata[16:0] <= 17'd46341, "magnitude out of range")
  `PRC_ASSERT_NOW(a_angle_range, polar_word, !m_axis_tdata[33] && m_axis_tdata[39:34] == 6'd0, "angle out of range")
  `PRC_ASSERT_NOW(a_ready_passes, m_axis_tready, s_axis_tready, "input stalled while output ready")

endmodule

bind polar_rectangular_converter prc_checker u_prc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_top.sv
// Self-checking testbench: directed and random words checked by a CORDIC model or fixed values.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prc_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_BITS    = 16;
  localparam int PIPE_DEPTH    = CORDIC_STAGES + 3;
  localparam int RANDOM_WORDS  = 2000;
  localparam int DIR_ROWS      = 24;
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint GAIN_K    = 64'sd2608131496
                               + ((64'sd2608131496 / 3) >>> (2 * CORDIC_STAGES - 1));

  localparam logic [31:0] ATAN_STEP [0:15] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic               kind;
    logic signed [15:0] a;
    logic signed [16:0] b;
  } conv_req_t;

  typedef struct packed {
    logic [16:0] a;
    logic [16:0] b;
    logic        kind;
  } conv_res_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] a;
    logic signed [16:0] b;
    bit                 known;
    logic [16:0]        ea;
    logic [16:0]        eb;
  } dir_row_t;

  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    '{REQ_P2C, 16'h0000, 17'h00000, 1'b1, 17'd0, 17'd0},
    '{REQ_P2C, 16'h8000, 17'h04000, 1'b1, 17'd0, 17'd0},
    '{REQ_P2C, 16'hFFFF, 17'h0FFFF, 1'b1, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h00000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h04000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h08000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h0C000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h0FFFF, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h02000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h18000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h1FFFF, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h0001, 17'h06000, 1'b0, 17'd0, 17'd0},
    '{REQ_P2C, 16'h7FFF, 17'h0A000, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h0000, 17'h00000, 1'b1, 17'd0, 17'd0},
    '{REQ_C2P, 16'h0000, 17'h003E8, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h0000, 17'h1FC18, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h8000, 17'h00000, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h7FFF, 17'h00000, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h8000, 17'h18000, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h7FFF, 17'h0FFFF, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'hFFFF, 17'h18000, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h0064, 17'h1FFFF, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h8000, 17'h0FFFF, 1'b0, 17'd0, 17'd0},
    '{REQ_C2P, 16'h7FFF, 17'h07FFF, 1'b0, 17'd0, 17'd0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  conv_res_t pending_results [$];
  int        mismatch_count = 0;
  bit        tx_burst = 1'b0;
  bit        rx_burst = 1'b0;
  int        rx_hold = 0;
  int        rx_next;

  polar_rectangular_converter #(
    .DATA_WIDTH(COORD_BITS),
    .ITERATIONS(CORDIC_STAGES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_coord(input longint v);
    return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic conv_res_t predict_conversion(input conv_req_t rq);
    conv_res_t r;
    longint    vx, vy, nx, ny, mag, ra, rb;
    logic [31:0] ang;
    bit        turn;
    int        i;
    r.kind = rq.kind;
    ra = 0;
    rb = 0;
    if (rq.kind == REQ_P2C) begin
      vx = longint'(rq.a);
      if (vx < 0) vx = 0;
      ang = {rq.b[15:0], 16'h0000};
      turn = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      if (turn) ang = ang + 32'h8000_0000;
      vx = (vx * GAIN_K + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
      if (turn) vx = -vx;
      vy = 0;
      for (i = 0; i < CORDIC_STAGES; i++) begin
        if (!ang[31]) begin
          nx = vx - (vy >>> i);
          ny = vy + (vx >>> i);
          ang = ang - ATAN_STEP[i];
        end else begin
          nx = vx + (vy >>> i);
          ny = vy - (vx >>> i);
          ang = ang + ATAN_STEP[i];
        end
        vx = nx;
        vy = ny;
      end
      ra = clamp_coord((vx + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
      rb = clamp_coord((vy + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
    end else begin
      vx = longint'(rq.a);
      vy = clamp_coord(longint'(rq.b));
      if (vx != 0 || vy != 0) begin
        ang = 32'h0000_0000;
        if (vx < 0) begin
          vx = -vx;
          vy = -vy;
          ang = 32'h8000_0000;
        end
        vx = vx <<< FRAC;
        vy = vy <<< FRAC;
        for (i = 0; i < CORDIC_STAGES; i++) begin
          if (vy < 0) begin
            nx = vx - (vy >>> i);
            ny = vy + (vx >>> i);
            ang = ang - ATAN_STEP[i];
          end else begin
            nx = vx + (vy >>> i);
            ny = vy - (vx >>> i);
            ang = ang + ATAN_STEP[i];
          end
          vx = nx;
          vy = ny;
        end
        if (vx < 0) vx = 0;
        mag = (vx * GAIN_K + (64'sd1 <<< (FRAC + 31))) >>> (FRAC + 32);
        ra = (mag > MAG_MAX) ? longint'(MAG_MAX) : mag;
        ang = ang + 32'h0000_8000;
        rb = longint'(ang[31:16]);
      end
    end
    r.a = ra[16:0];
    r.b = rb[16:0];
    return r;
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t rq;
    int        pick;
    rq.kind = $urandom_range(0, 1) ? REQ_C2P : REQ_P2C;
    pick = $urandom_range(0, 9);
    if (rq.kind == REQ_P2C) begin
      rq.a = (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, 32767));
      rq.b = 17'(int'($urandom_range(0, 98303)) - 32768);
    end else begin
      case (pick)
        0: begin
          rq.a = 16'h0000;
          rq.b = 17'(int'($urandom_range(0, 98303)) - 32768);
        end
        1: begin
          rq.a = 16'(int'($urandom_range(0, 16)) - 8);
          rq.b = 17'(int'($urandom_range(0, 16)) - 8);
        end
        2: begin
          rq.a = 16'($urandom);
          rq.b = 17'(int'($urandom_range(0, 98303)) - 32768);
        end
        default: begin
          rq.a = 16'($urandom);
          rq.b = 17'(int'($urandom_range(0, 65535)) - 32768);
        end
      endcase
    end
    return rq;
  endfunction

  task automatic send_word(input conv_req_t rq, input conv_res_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - IN_A_W - IN_B_W){1'b0}}, rq.b, rq.a};
    s_axis_tuser  <= rq.kind;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(want);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string field, input logic [16:0] want,
                              input logic [16:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d",
             $time, field, $signed(want), $signed(got));
  endtask

  task automatic check_result(input conv_res_t got);
    conv_res_t want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected word, expected none, actual a=%0d b=%0d type=%0d",
               $time, $signed(got.a), $signed(got.b), got.kind);
    end else begin
      want = pending_results.pop_front();
      if (got.a !== want.a) report_field("out_a", want.a, got.a);
      if (got.b !== want.b) report_field("out_b", want.b, got.b);
      if (got.kind !== want.kind)
        report_field("out_type", {16'd0, want.kind}, {16'd0, got.kind});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_hold       <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result('{m_axis_tdata[16:0], m_axis_tdata[33:17], m_axis_tuser});
        rx_next = rx_burst ? 0 : $urandom_range(0, 4);
      end else if (rx_hold > 0) begin
        rx_next = rx_hold - 1;
      end else begin
        rx_next = 0;
      end
      rx_hold       <= rx_next;
      m_axis_tready <= (rx_next == 0);
    end
  end

  initial begin
    conv_req_t rq;
    conv_res_t want;
    int        k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (k = 0; k < DIR_ROWS; k++) begin
      rq = '{DIRECTED[k].kind, DIRECTED[k].a, DIRECTED[k].b};
      if (DIRECTED[k].known)
        want = '{DIRECTED[k].ea, DIRECTED[k].eb, DIRECTED[k].kind};
      else
        want = predict_conversion(rq);
      send_word(rq, want);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 100 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst <= ($urandom_range(0, 3) == 0);
      end
      if (k == RANDOM_WORDS / 2) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      rq = random_request();
      send_word(rq, predict_conversion(rq));
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0)
      $display("polar_rectangular_converter regression: pass");
    else
      $display("polar_rectangular_converter regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("polar_rectangular_converter regression: fail");
    $finish;
  end

endmodule

FILE: polar_rectangular_converter.f
+incdir+rtl
rtl/prc_pkg.sv
rtl/prc_prep.sv
rtl/prc_cell.sv
rtl/prc_post.sv
rtl/polar_rectangular_converter.sv
rtl/prc_checker.sv
tb/tb_top.sv
